@@ sv/grid_bitset_spatial_index_core_assert.svh @@
// Assertion macros shared by the grid bitset spatial index RTL.
`ifndef GRID_BITSET_SPATIAL_INDEX_CORE_ASSERT_SVH
`define GRID_BITSET_SPATIAL_INDEX_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define GBSI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define GBSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/gbsi_pkg.sv @@
// Shared types and constants of the grid bitset spatial index.
package gbsi_pkg;

    // Default geometry and capacity
    localparam int COLUMNS_DEF  = 16;
    localparam int ROWS_DEF     = 16;
    localparam int CELL_SIZE_DEF = 64;
    localparam int CAPACITY_DEF = 256;

    // Fixed field widths
    localparam int WORD_BITS = 64;
    localparam int COORD_W   = 24;
    localparam int CALC_W    = 40;
    localparam int IDX_W     = 8;
    localparam int CNT_W     = 9;
    localparam int CAPCMP_W  = 13;
    localparam int WN_W      = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Configuration register indexes
    localparam logic CFG_ORIGIN_X = 1'b0;
    localparam logic CFG_ORIGIN_Y = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Work kinds handed to the back end
    typedef enum logic [2:0] {
        K_CLEAR  = 3'd0,
        K_SINGLE = 3'd1,
        K_SET    = 3'd2,
        K_QCELL  = 3'd3,
        K_QMASK  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               status;
        logic [IDX_W-1:0]   id;
        logic [IDX_W-1:0]   x0;
        logic [IDX_W-1:0]   x1;
        logic [IDX_W-1:0]   y0;
        logic [IDX_W-1:0]   y1;
        logic [CNT_W-1:0]   cnt;
    } t_cmd;

endpackage

@@ sv/grid_bitset_spatial_index_core.sv @@
// Work after acceptance, back end idle: single-result ops give one result; clear sweeps the
// whole memory; an in-world append does a read-modify-write per cell of its range; an in-world
// query reads its cells once per word, other queries give count masks, one result per word.
// The front takes a new item only once the last is pushed, and stalls while the
// two-entry queue is full; results are one-cycle strobes, never stalled.
// Reset is synchronous; the memory is then cleared.
module grid_bitset_spatial_index_core import gbsi_pkg::*; #(
    parameter int COLUMNS     = COLUMNS_DEF,
    parameter int ROWS        = ROWS_DEF,
    parameter int CELL_SIZE   = CELL_SIZE_DEF,
    parameter int MAX_STROKES = CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_op,
    input  logic [IDX_W-1:0]          i_stroke_id,
    input  logic signed [COORD_W-1:0] i_box_left,
    input  logic signed [COORD_W-1:0] i_box_top,
    input  logic signed [COORD_W-1:0] i_box_right,
    input  logic signed [COORD_W-1:0] i_box_bottom,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [COORD_W-1:0]        i_cfg_data,
    output logic                      o_valid,
    output logic                      o_status,
    output logic [WORD_BITS-1:0]      o_mask_word,
    output logic [WN_W-1:0]           o_word_number,
    output logic                      o_final_res
);

    logic signed [COORD_W-1:0] r_origin_x, r_origin_y;
    logic w_push, w_full, w_pop, w_q_vld;
    t_cmd w_cmd_in, w_cmd_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gbsi_front #(
        .COLUMNS(COLUMNS), .ROWS(ROWS), .CELL_SIZE(CELL_SIZE),
        .MAX_STROKES(MAX_STROKES)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_op(i_op), .i_stroke_id(i_stroke_id),
        .i_box_left(i_box_left), .i_box_top(i_box_top),
        .i_box_right(i_box_right), .i_box_bottom(i_box_bottom),
        .i_origin_x(r_origin_x), .i_origin_y(r_origin_y),
        .i_full(w_full), .o_push(w_push), .o_cmd(w_cmd_in)
    );

    gbsi_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_cmd(w_cmd_in), .o_full(w_full),
        .i_pop(w_pop), .o_vld(w_q_vld), .o_cmd(w_cmd_out)
    );

    gbsi_back #(
        .COLUMNS(COLUMNS), .ROWS(ROWS), .MAX_STROKES(MAX_STROKES)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_vld(w_q_vld), .i_q_cmd(w_cmd_out), .o_pop(w_pop),
        .o_valid(o_valid), .o_status(o_status), .o_mask_word(o_mask_word),
        .o_word_number(o_word_number), .o_final_res(o_final_res)
    );

endmodule

@@ sv/gbsi_front.sv @@
// Front end: accepts items, validates and classifies them, finds cell ranges.
module gbsi_front import gbsi_pkg::*; #(
    parameter int COLUMNS     = COLUMNS_DEF,
    parameter int ROWS        = ROWS_DEF,
    parameter int CELL_SIZE   = CELL_SIZE_DEF,
    parameter int MAX_STROKES = CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [1:0]                i_op,
    input  logic [IDX_W-1:0]          i_stroke_id,
    input  logic signed [COORD_W-1:0] i_box_left,
    input  logic signed [COORD_W-1:0] i_box_top,
    input  logic signed [COORD_W-1:0] i_box_right,
    input  logic signed [COORD_W-1:0] i_box_bottom,
    input  logic signed [COORD_W-1:0] i_origin_x,
    input  logic signed [COORD_W-1:0] i_origin_y,
    input  logic                      i_full,
    output logic                      o_push,
    output t_cmd                      o_cmd
);

    localparam longint CELL_RAW_L = longint'(CELL_SIZE) * 256;
    localparam logic signed [CALC_W-1:0] CELL_RAW = CALC_W'(CELL_RAW_L);
    localparam logic signed [CALC_W-1:0] SPAN_X   = CALC_W'(CELL_RAW_L * COLUMNS);
    localparam logic signed [CALC_W-1:0] SPAN_Y   = CALC_W'(CELL_RAW_L * ROWS);
    localparam logic [IDX_W-1:0] LIM_X = IDX_W'(COLUMNS - 1);
    localparam logic [IDX_W-1:0] LIM_Y = IDX_W'(ROWS - 1);

    typedef enum logic [1:0] {F_IDLE, F_CLS, F_DIV, F_PUSH} t_fstate;

    t_fstate                   r_state;
    t_op                       r_op;
    logic [IDX_W-1:0]          r_id;
    logic signed [CALC_W-1:0]  r_l, r_t, r_r, r_b;
    logic [CNT_W-1:0]          r_count;
    logic signed [CALC_W-1:0]  r_d [4];
    logic [IDX_W-1:0]          r_c [4];
    t_cmd                      r_cmd;

    logic signed [CALC_W-1:0]  w_ox, w_oy;
    logic                      w_inside, w_ordered, w_app_ok;
    logic [3:0]                w_adv;

    // World bounds and append validity
    assign w_ox = CALC_W'(i_origin_x);
    assign w_oy = CALC_W'(i_origin_y);
    assign w_inside = (r_l >= w_ox) && (r_t >= w_oy) &&
                      (r_r < w_ox + SPAN_X) && (r_b < w_oy + SPAN_Y);
    assign w_ordered = (r_l <= r_r) && (r_t <= r_b);
    assign w_app_ok  = ({1'b0, r_id} == r_count) &&
                       (CAPCMP_W'(r_id) < CAPCMP_W'(MAX_STROKES)) && w_ordered;

    // One subtract step per coordinate per cycle; even indexes are x
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_adv[k] = (r_d[k] >= CELL_RAW) &&
                       (r_c[k] < (((k % 2) == 0) ? LIM_X : LIM_Y));
        end
    end

    assign o_busy = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_cmd  = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_op    <= t_op'(i_op);
                        r_id    <= i_stroke_id;
                        r_l     <= CALC_W'(i_box_left);
                        r_t     <= CALC_W'(i_box_top);
                        r_r     <= CALC_W'(i_box_right);
                        r_b     <= CALC_W'(i_box_bottom);
                        r_state <= F_CLS;
                    end
                end
                F_CLS: begin
                    r_cmd.status <= 1'b0;
                    r_cmd.id     <= r_id;
                    r_cmd.cnt    <= r_count;
                    r_d[0] <= r_l - w_ox;
                    r_d[1] <= r_t - w_oy;
                    r_d[2] <= r_r - w_ox;
                    r_d[3] <= r_b - w_oy;
                    for (int k = 0; k < 4; k++) r_c[k] <= '0;
                    r_state <= F_PUSH;
                    unique case (r_op)
                        OP_CLEAR: begin
                            r_count    <= '0;
                            r_cmd.kind <= K_CLEAR;
                        end
                        OP_APPEND: begin
                            r_cmd.kind <= K_SINGLE;
                            if (!w_app_ok) begin
                                r_cmd.status <= 1'b1;
                            end else begin
                                r_count <= r_count + 1'b1;
                                if (w_inside) begin
                                    r_cmd.kind <= K_SET;
                                    r_state    <= F_DIV;
                                end
                            end
                        end
                        OP_QUERY: begin
                            r_cmd.kind <= K_QMASK;
                            if (w_inside) begin
                                r_cmd.kind <= K_QCELL;
                                r_state    <= F_DIV;
                            end
                        end
                        OP_NONE: begin
                            r_cmd.kind <= K_SINGLE;
                        end
                        default: begin
                            r_cmd.kind <= K_SINGLE;
                        end
                    endcase
                end
                F_DIV: begin
                    if (w_adv != 4'b0) begin
                        for (int k = 0; k < 4; k++) begin
                            if (w_adv[k]) begin
                                r_d[k] <= r_d[k] - CELL_RAW;
                                r_c[k] <= r_c[k] + 1'b1;
                            end
                        end
                    end else begin
                        r_cmd.x0 <= r_c[0];
                        r_cmd.y0 <= r_c[1];
                        r_cmd.x1 <= r_c[2];
                        r_cmd.y1 <= r_c[3];
                        // Reversed cell range visits no cell: all-zero words
                        if ((r_cmd.kind == K_QCELL) &&
                            ((r_c[0] > r_c[2]) || (r_c[1] > r_c[3]))) begin
                            r_cmd.kind <= K_QMASK;
                            r_cmd.cnt  <= '0;
                        end
                        r_state  <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

@@ sv/gbsi_fifo.sv @@
// Short command queue between the front and back ends.
module gbsi_fifo import gbsi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_vld,
    output t_cmd o_cmd
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_cmd  = r_q[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_cmd;
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

endmodule

@@ sv/gbsi_back.sv @@
// Back end: bitset memory, clear sweep, append read-modify-write, query walk.
module gbsi_back import gbsi_pkg::*; #(
    parameter int COLUMNS     = COLUMNS_DEF,
    parameter int ROWS        = ROWS_DEF,
    parameter int MAX_STROKES = CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_vld,
    input  t_cmd                 i_q_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    output logic                 o_status,
    output logic [WORD_BITS-1:0] o_mask_word,
    output logic [WN_W-1:0]      o_word_number,
    output logic                 o_final_res
);

`include "grid_bitset_spatial_index_core_assert.svh"

    localparam int WORDS = (MAX_STROKES + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH = COLUMNS * ROWS * WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_CLR, S_ARD, S_AWR, S_QISS, S_QWAIT, S_QMASK
    } t_bstate;

    logic [WORD_BITS-1:0] r_mem [DEPTH];

    t_bstate              r_state;
    t_cmd                 r_cmd;
    logic [IDX_W-1:0]     r_x, r_y;
    logic [WW-1:0]        r_w;
    logic [AW-1:0]        r_ca;
    logic [WORD_BITS-1:0] r_acc, r_rd;
    logic                 r_rdv;
    logic                 r_valid, r_status, r_final;
    logic [WORD_BITS-1:0] r_mask;
    logic [WN_W-1:0]      r_wn;

    logic [AW-1:0]        w_addr;
    logic                 w_we, w_re, w_clr;
    logic [AW-1:0]        w_wa;
    logic [WORD_BITS-1:0] w_wd, w_acc_next, w_cnt_mask;
    logic                 w_row_end, w_last_cell, w_last_word, w_last_ca;
    int                   w_lo, w_c;

    // Memory address of the current cell and word
    assign w_addr = AW'((int'(r_y) * COLUMNS + int'(r_x)) * WORDS + int'(r_w));

    assign w_clr = (r_state == S_INIT) || (r_state == S_CLR);
    assign w_we  = w_clr || (r_state == S_AWR);
    assign w_wa  = w_clr ? r_ca : w_addr;
    assign w_wd  = w_clr ? '0 : (r_rd | (WORD_BITS'(1) << r_cmd.id[5:0]));
    assign w_re  = (r_state == S_ARD) || (r_state == S_QISS);

    assign w_row_end   = (r_x == r_cmd.x1);
    assign w_last_cell = w_row_end && (r_y == r_cmd.y1);
    assign w_last_word = (r_w == WW'(WORDS - 1));
    assign w_last_ca   = (r_ca == AW'(DEPTH - 1));
    assign w_acc_next  = r_acc | (r_rdv ? r_rd : '0);

    // Mask of strokes below the count for word r_w
    always_comb begin
        w_lo = int'(r_w) * WORD_BITS;
        w_c  = int'(r_cmd.cnt);
        if (w_c >= w_lo + WORD_BITS) w_cnt_mask = '1;
        else if (w_c > w_lo)         w_cnt_mask = ~('1 << (w_c - w_lo));
        else                         w_cnt_mask = '0;
    end

    assign o_pop         = (r_state == S_IDLE) && i_q_vld;
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_mask_word   = r_mask;
    assign o_word_number = r_wn;
    assign o_final_res   = r_final;

    // Bitset memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (w_re) r_rd <= r_mem[w_addr];
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ca    <= '0;
            r_rdv   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_rdv   <= w_re;
            r_valid <= 1'b0;
            r_acc   <= w_acc_next;
            unique case (r_state)
                S_INIT: begin
                    r_ca <= r_ca + 1'b1;
                    if (w_last_ca) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_q_vld) begin
                        r_cmd <= i_q_cmd;
                        r_x   <= i_q_cmd.x0;
                        r_y   <= i_q_cmd.y0;
                        r_w   <= '0;
                        r_ca  <= '0;
                        r_acc <= '0;
                        unique case (i_q_cmd.kind)
                            K_CLEAR: r_state <= S_CLR;
                            K_SET: begin
                                r_w     <= WW'(i_q_cmd.id >> 6);
                                r_state <= S_ARD;
                            end
                            K_QCELL: r_state <= S_QISS;
                            K_QMASK: r_state <= S_QMASK;
                            default: begin
                                r_valid  <= 1'b1;
                                r_status <= i_q_cmd.status;
                                r_mask   <= '0;
                                r_wn     <= '0;
                                r_final  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_ca <= r_ca + 1'b1;
                    if (w_last_ca) begin
                        r_valid  <= 1'b1;
                        r_status <= 1'b0;
                        r_mask   <= '0;
                        r_wn     <= '0;
                        r_final  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_ARD: r_state <= S_AWR;
                S_AWR: begin
                    if (w_last_cell) begin
                        r_valid  <= 1'b1;
                        r_status <= 1'b0;
                        r_mask   <= '0;
                        r_wn     <= '0;
                        r_final  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_x <= w_row_end ? r_cmd.x0 : r_x + 1'b1;
                        if (w_row_end) r_y <= r_y + 1'b1;
                        r_state <= S_ARD;
                    end
                end
                S_QISS: begin
                    if (w_last_cell) begin
                        r_state <= S_QWAIT;
                    end else begin
                        r_x <= w_row_end ? r_cmd.x0 : r_x + 1'b1;
                        if (w_row_end) r_y <= r_y + 1'b1;
                    end
                end
                S_QWAIT: begin
                    r_valid  <= 1'b1;
                    r_status <= 1'b0;
                    r_mask   <= w_acc_next;
                    r_wn     <= WN_W'(r_w);
                    r_final  <= w_last_word;
                    r_acc    <= '0;
                    r_x      <= r_cmd.x0;
                    r_y      <= r_cmd.y0;
                    r_w      <= r_w + 1'b1;
                    r_state  <= w_last_word ? S_IDLE : S_QISS;
                end
                S_QMASK: begin
                    r_valid  <= 1'b1;
                    r_status <= 1'b0;
                    r_mask   <= w_cnt_mask;
                    r_wn     <= WN_W'(r_w);
                    r_final  <= w_last_word;
                    r_w      <= r_w + 1'b1;
                    if (w_last_word) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `GBSI_ASSERT_NEXT(a_init_silent, r_state == S_INIT, !r_valid, "result during clear sweep")
    `GBSI_ASSERT_SAME(a_awr_after_ard, r_state == S_AWR, $past(r_state) == S_ARD, "write without read")
    `GBSI_ASSERT_SAME(a_qwait_data, r_state == S_QWAIT, r_rdv, "last query read missing")

endmodule
